// ===== hw/rtl/drysp_pkg.sv =====
// drysp_pkg: shared types, codes and round functions of the drysponge f engine
// depends on nothing
`timescale 1ns / 1ps
package drysp_pkg;
    localparam int BLOCK_BYTES = 16;
    localparam int LEN_W       = 5;

    typedef enum logic [1:0] {
        CMD_LOAD    = 2'd0,
        CMD_ABSORB  = 2'd1,
        CMD_SQUEEZE = 2'd2,
        CMD_NOP     = 2'd3
    } t_cmd;

    localparam logic [2:0] CFG_X_LOW  = 3'd0;
    localparam logic [2:0] CFG_X_HIGH = 3'd1;

    typedef logic [63:0] t_word;
    typedef t_word t_state [5];

    // controller to datapath
    typedef struct packed {
        logic       capture;    // take input item
        logic       mix;        // xor group into state
        logic       round;      // run one core round
        logic [3:0] rc_idx;     // round constant index
        logic [3:0] grp;        // mix group 0..13
        logic       r_clear;    // clear r accumulator
        logic       r_acc;      // fold state into r
        logic       load;       // load word
        logic       out_zero;   // result is zero
        logic       out_take;   // latch result into output register
    } t_cmd_bus;

    function automatic logic [31:0] rot32(input logic [31:0] v, input int n);
        logic [63:0] d;
        d = {v, v} >> (n % 32);
        return d[31:0];
    endfunction

    function automatic t_word irot(input t_word x, input int n);
        logic [31:0] lo, hi;
        lo = x[31:0];
        hi = x[63:32];
        if (n % 2 == 0) return {rot32(hi, n / 2), rot32(lo, n / 2)};
        return {rot32(lo, n / 2 + 1), rot32(hi, n / 2)};
    endfunction

    function automatic t_state core_round(input t_state c, input logic [3:0] idx);
        t_word a0, a1, a2, a3, a4, t0, t1, t2, t3, t4;
        t_state o;
        a0 = c[0]; a1 = c[1]; a2 = c[2]; a3 = c[3]; a4 = c[4];
        a2 = a2 ^ {56'd0, 4'hF - idx, idx};
        a0 ^= a4; a2 ^= a1; a4 ^= a3;
        t0 = ~a0 & a1; t1 = ~a1 & a2; t2 = ~a2 & a3; t3 = ~a3 & a4; t4 = ~a4 & a0;
        a0 ^= t1; a1 ^= t2; a2 ^= t3; a3 ^= t4; a4 ^= t0;
        a1 ^= a0; a3 ^= a2; a0 ^= a4; a2 = ~a2;
        o[0] = a0 ^ irot(a0, 19) ^ irot(a0, 28);
        o[1] = a1 ^ irot(a1, 61) ^ irot(a1, 38);
        o[2] = a2 ^ irot(a2, 1) ^ irot(a2, 6);
        o[3] = a3 ^ irot(a3, 10) ^ irot(a3, 17);
        o[4] = a4 ^ irot(a4, 7) ^ irot(a4, 40);
        return o;
    endfunction
endpackage

// ===== hw/rtl/drysp_datapath.sv =====
// drysp_datapath: gascon state, block padding, group mixing, r accumulation
// depends on drysp_pkg
`timescale 1ns / 1ps
module drysp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  drysp_pkg::t_cmd_bus  i_cmd,
    input  logic [2:0]           i_word_index,
    input  logic [63:0]          i_word_data,
    input  logic [63:0]          i_block_low,
    input  logic [63:0]          i_block_high,
    input  logic [4:0]           i_block_len,
    input  logic [19:0]          i_domain,
    input  logic [63:0]          i_x_low,
    input  logic [63:0]          i_x_high,
    output logic [63:0]          o_r_low,
    output logic [63:0]          o_r_high
);
    import drysp_pkg::*;

    t_state r_c, n_c, c_mixed;
    logic [127:0] r_blk;
    logic [19:0]  r_ds;
    logic [127:0] r_acc, n_acc;
    logic [127:0] padded;
    logic [9:0]   grp_bits;
    logic [2:0]   r_widx;
    logic [63:0]  r_wdata;
    logic [63:0]  r_out_lo, r_out_hi;
    t_state       c_rnd;

    // pad a block shorter than 16 bytes: 0x01 after the last valid byte, zeros above
    always_comb begin
        padded = {i_block_high, i_block_low};
        for (int b = 0; b < BLOCK_BYTES; b++) begin
            if (i_block_len < LEN_W'(BLOCK_BYTES)) begin
                if (LEN_W'(b) == i_block_len) padded[8*b +: 8] = 8'h01;
                else if (LEN_W'(b) > i_block_len) padded[8*b +: 8] = 8'h00;
            end
        end
    end

    always_comb begin
        case (i_cmd.grp)
            4'd12:   grp_bits = {2'b00, r_blk[127:120]} ^ r_ds[9:0];
            4'd13:   grp_bits = r_ds[19:10];
            default: grp_bits = r_blk[10*i_cmd.grp +: 10];
        endcase
        for (int k = 0; k < 5; k++) begin
            case (grp_bits[2*k +: 2])
                2'd0:    c_mixed[k] = r_c[k] ^ {32'd0, i_x_low[31:0]};
                2'd1:    c_mixed[k] = r_c[k] ^ {32'd0, i_x_low[63:32]};
                2'd2:    c_mixed[k] = r_c[k] ^ {32'd0, i_x_high[31:0]};
                default: c_mixed[k] = r_c[k] ^ {32'd0, i_x_high[63:32]};
            endcase
        end
    end

    assign c_rnd = core_round(r_c, i_cmd.rc_idx);

    always_comb begin
        n_c = r_c;
        if (i_cmd.load && r_widx < 3'd5) n_c[r_widx] = r_wdata;
        else if (i_cmd.mix) n_c = c_mixed;
        else if (i_cmd.round) n_c = c_rnd;
        n_acc = r_acc;
        if (i_cmd.r_clear) n_acc = '0;
        else if (i_cmd.r_acc) n_acc = r_acc ^ {
            c_rnd[1][63:32] ^ c_rnd[2][31:0], c_rnd[1][31:0] ^ c_rnd[3][63:32],
            c_rnd[0][63:32] ^ c_rnd[3][31:0], c_rnd[0][31:0] ^ c_rnd[2][63:32]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 5; k++) r_c[k] <= '0;
        end else begin
            r_c <= n_c;
        end
        r_acc <= n_acc;
        if (i_cmd.capture) begin
            r_blk   <= padded;
            r_ds    <= i_domain;
            r_widx  <= i_word_index;
            r_wdata <= i_word_data;
        end
        if (i_cmd.out_take) begin
            r_out_lo <= i_cmd.out_zero ? '0 : r_acc[63:0];
            r_out_hi <= i_cmd.out_zero ? '0 : r_acc[127:64];
        end
    end

    assign o_r_low  = r_out_lo;
    assign o_r_high = r_out_hi;
endmodule

// ===== hw/rtl/drysp_ctrl.sv =====
// drysp_ctrl: sequencer for load, mix phase and g rounds, output handshake
// depends on drysp_pkg
`timescale 1ns / 1ps
module drysp_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [1:0]          i_command,
    input  logic [3:0]          i_rounds,
    output logic                o_valid,
    input  logic                i_stall,
    output drysp_pkg::t_cmd_bus o_cmd
);
    import drysp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_MIX   = 6'b000100,
        S_MROUND= 6'b001000,
        S_G     = 6'b010000,
        S_DONE  = 6'b100000
    } t_state_e;

    t_state_e r_st, n_st;
    t_cmd     r_op;
    logic [3:0] r_grp, n_grp, r_cnt, n_cnt, r_nr;
    logic r_ov, n_ov;
    logic acc_in;

    // a waiting result only holds the sequencer in done
    assign o_stall = (r_st != S_IDLE);
    assign acc_in  = i_valid && !o_stall;
    assign o_valid = r_ov;

    always_comb begin
        n_st = r_st; n_grp = r_grp; n_cnt = r_cnt;
        n_ov = r_ov && i_stall;
        o_cmd = '0;
        o_cmd.grp = r_grp;
        o_cmd.rc_idx = r_cnt;
        case (r_st)
            S_IDLE: begin
                o_cmd.capture = acc_in;
                o_cmd.r_clear = 1'b1;
                if (acc_in) begin
                    n_grp = '0; n_cnt = '0;
                    case (t_cmd'(i_command))
                        CMD_LOAD:   n_st = S_LOAD;
                        CMD_ABSORB: n_st = S_MIX;
                        CMD_SQUEEZE: n_st = S_G;
                        default:    n_st = S_DONE;
                    endcase
                end
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_st = S_DONE;
            end
            S_MIX: begin
                o_cmd.mix = 1'b1;
                n_grp = r_grp + 4'd1;
                n_st = (r_grp == 4'd13) ? S_G : S_MROUND;
            end
            S_MROUND: begin
                o_cmd.round = 1'b1;
                o_cmd.rc_idx = '0;
                n_st = S_MIX;
            end
            S_G: begin
                o_cmd.round = 1'b1;
                o_cmd.r_acc = 1'b1;
                n_cnt = r_cnt + 4'd1;
                if (n_cnt >= r_nr || r_cnt == 4'd15) n_st = S_DONE;
            end
            S_DONE: begin
                if (!(r_ov && i_stall)) begin
                    o_cmd.out_take = 1'b1;
                    o_cmd.out_zero = (r_op != CMD_ABSORB) && (r_op != CMD_SQUEEZE);
                    n_ov = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_ov <= 1'b0; r_grp <= '0; r_cnt <= '0;
        end else begin
            r_st <= n_st; r_ov <= n_ov; r_grp <= n_grp; r_cnt <= n_cnt;
        end
        if (acc_in) begin
            r_op <= t_cmd'(i_command);
            r_nr <= i_rounds;
        end
    end
endmodule

// ===== hw/rtl/drysponge128_f_engine_core.sv =====
// drysponge128_f_engine_core: top level of the drysponge128 f/g engine
// depends on drysp_pkg, drysp_ctrl, drysp_datapath
// steps: load goes idle, load, done; squeeze runs the g rounds, then done; absorb alternates
// mix and core round over groups 0..13, then g rounds, then done (one core round per cycle)
// one item at a time; the next item is taken once the sequencer is back in idle
// a result still waiting in the output register stalls the next item only at its end
// reset: synchronous active-low clears state words, x registers and the sequencer state, group, round count and valid
`timescale 1ns / 1ps
module drysponge128_f_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [2:0]  i_word_index,
    input  logic [63:0] i_word_data,
    input  logic [63:0] i_block_low,
    input  logic [63:0] i_block_high,
    input  logic [4:0]  i_block_len,
    input  logic [19:0] i_domain,
    input  logic [3:0]  i_rounds,
    // result output
    output logic        o_valid,
    input  logic        i_stall,
    output logic [63:0] o_r_low,
    output logic [63:0] o_r_high,
    // config write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data
);
    import drysp_pkg::*;

    t_cmd_bus cmd;
    logic [63:0] r_x_low, r_x_high;

    // x registers, always writable
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x_low <= '0; r_x_high <= '0;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_X_LOW)  r_x_low  <= i_cfg_data;
            if (i_cfg_index == CFG_X_HIGH) r_x_high <= i_cfg_data;
        end
    end

    drysp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_command, .i_rounds,
        .o_valid, .i_stall, .o_cmd(cmd)
    );

    drysp_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(cmd), .i_word_index, .i_word_data,
        .i_block_low, .i_block_high, .i_block_len, .i_domain,
        .i_x_low(r_x_low), .i_x_high(r_x_high), .o_r_low, .o_r_high
    );
endmodule

// ===== tb/drysponge128_f_engine_core_tb.sv =====
// drysponge128_f_engine_core_tb: self-checking bench for the drysponge128 f/g engine
// depends on drysp_pkg and drysponge128_f_engine_core; predicts each r result in-bench
`timescale 1ns / 1ps
module drysponge128_f_engine_core_tb;
    import drysp_pkg::*;

    localparam int WATCHDOG_LIMIT = 8000;   // cycles with no handshake at all
    localparam int SETTLE_CYCLES  = 60;     // longer than the slowest absorb

    typedef struct {
        logic [63:0] lo;
        logic [63:0] hi;
    } t_r_pair;

    // dut signals
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [1:0]  i_command = CMD_LOAD;
    logic [2:0]  i_word_index = '0;
    logic [63:0] i_word_data = '0;
    logic [63:0] i_block_low = '0;
    logic [63:0] i_block_high = '0;
    logic [4:0]  i_block_len = '0;
    logic [19:0] i_domain = '0;
    logic [3:0]  i_rounds = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [63:0] o_r_low;
    logic [63:0] o_r_high;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [63:0] i_cfg_data = '0;

    // bench-side copy of the engine state
    t_word       sp_c [5];
    logic [63:0] sp_x_low, sp_x_high;
    t_r_pair     r_expect_q [$];

    int          send_idle_pct = 0;   // sender gap chance per cycle
    int          recv_stall_pct = 0;  // receiver stall chance per cycle
    int          recv_hold_cycles = 0; // long receiver hold-off, counted down
    int          err_count = 0;
    int          quiet_cycles = 0;

    drysponge128_f_engine_core dut (.*);

    always #5 i_clk = ~i_clk;

    // ---------------- predictor ----------------

    function automatic logic [31:0] ror32(input logic [31:0] v, input int n);
        if (n == 0) return v;
        return (v >> n) | (v << (32 - n));
    endfunction

    // interleaved right rotation of a 64-bit word
    function automatic t_word iror(input t_word w, input int n);
        int b;
        b = n / 2;
        if (n % 2 == 0) return {ror32(w[63:32], b), ror32(w[31:0], b)};
        return {ror32(w[31:0], (b + 1) % 32), ror32(w[63:32], b)};
    endfunction

    task automatic gascon_round(input logic [3:0] idx);
        t_word a [5];
        t_word t [5];
        for (int k = 0; k < 5; k++) a[k] = sp_c[k];
        a[2] ^= {56'd0, 4'd15 - idx, idx};
        a[0] ^= a[4]; a[2] ^= a[1]; a[4] ^= a[3];
        for (int k = 0; k < 5; k++) t[k] = ~a[k] & a[(k + 1) % 5];
        for (int k = 0; k < 5; k++) a[k] ^= t[(k + 1) % 5];
        a[1] ^= a[0]; a[3] ^= a[2]; a[0] ^= a[4]; a[2] = ~a[2];
        sp_c[0] = a[0] ^ iror(a[0], 19) ^ iror(a[0], 28);
        sp_c[1] = a[1] ^ iror(a[1], 61) ^ iror(a[1], 38);
        sp_c[2] = a[2] ^ iror(a[2], 1) ^ iror(a[2], 6);
        sp_c[3] = a[3] ^ iror(a[3], 10) ^ iror(a[3], 17);
        sp_c[4] = a[4] ^ iror(a[4], 7) ^ iror(a[4], 40);
    endtask

    // each 2-bit selector picks one 32-bit x word into the low half of a state word
    task automatic mix_x_group(input logic [9:0] g);
        logic [1:0] sel;
        for (int k = 0; k < 5; k++) begin
            sel = g[2*k +: 2];
            case (sel)
                2'd0: sp_c[k] ^= {32'd0, sp_x_low[31:0]};
                2'd1: sp_c[k] ^= {32'd0, sp_x_low[63:32]};
                2'd2: sp_c[k] ^= {32'd0, sp_x_high[31:0]};
                default: sp_c[k] ^= {32'd0, sp_x_high[63:32]};
            endcase
        end
    endtask

    task automatic squeeze_rounds(input logic [3:0] n, output t_r_pair r);
        logic [31:0] r0, r1, r2, r3;
        int          i;
        r0 = '0; r1 = '0; r2 = '0; r3 = '0;
        i = 0;
        do begin
            gascon_round(i[3:0]);
            r0 ^= sp_c[0][31:0]  ^ sp_c[2][63:32];
            r1 ^= sp_c[0][63:32] ^ sp_c[3][31:0];
            r2 ^= sp_c[1][31:0]  ^ sp_c[3][63:32];
            r3 ^= sp_c[1][63:32] ^ sp_c[2][31:0];
            i++;
        end while (i < n);
        r.lo = {r1, r0};
        r.hi = {r3, r2};
    endtask

    task automatic absorb_block(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [4:0] len, input logic [19:0] ds);
        logic [127:0] blk, keep;
        blk = {hi, lo};
        if (len < BLOCK_BYTES) begin
            keep = (128'd1 << (8 * len)) - 128'd1;
            blk = (blk & keep) | (128'd1 << (8 * len));
        end
        for (int k = 0; k < 12; k++) begin
            mix_x_group(blk[10*k +: 10]);
            gascon_round(4'd0);
        end
        mix_x_group({2'b00, blk[127:120]} ^ ds[9:0]);
        gascon_round(4'd0);
        mix_x_group(ds[19:10]);
    endtask

    // works out the r result of one accepted item and queues it
    task automatic predict_r(input logic [1:0] cmd, input logic [2:0] widx,
                             input logic [63:0] wdata, input logic [63:0] blo,
                             input logic [63:0] bhi, input logic [4:0] len,
                             input logic [19:0] ds, input logic [3:0] nr);
        t_r_pair r;
        r.lo = '0;
        r.hi = '0;
        case (cmd)
            CMD_LOAD: if (widx < 5) sp_c[widx] = wdata;
            CMD_ABSORB: begin
                absorb_block(blo, bhi, len, ds);
                squeeze_rounds(nr, r);
            end
            CMD_SQUEEZE: squeeze_rounds(nr, r);
            default: ;
        endcase
        r_expect_q.push_back(r);
    endtask

    // ---------------- item traffic ----------------

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [2:0] widx,
                             input logic [63:0] wdata, input logic [63:0] blo,
                             input logic [63:0] bhi, input logic [4:0] len,
                             input logic [19:0] ds, input logic [3:0] nr);
        // random sender gaps, valid low meanwhile
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_command = cmd; i_word_index = widx; i_word_data = wdata;
        i_block_low = blo; i_block_high = bhi; i_block_len = len;
        i_domain = ds; i_rounds = nr; i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        predict_r(cmd, widx, wdata, blo, bhi, len, ds, nr);
        @(negedge i_clk);
    endtask

    task automatic stop_sending();
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        stop_sending();
        while (r_expect_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_x(input logic [2:0] idx, input logic [63:0] data);
        wait_drained();
        i_cfg_index = idx; i_cfg_data = data; i_cfg_valid = 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_X_LOW) sp_x_low = data;
        else if (idx == CFG_X_HIGH) sp_x_high = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic send_random_item();
        int          pick;
        logic [1:0]  cmd;
        logic [4:0]  len;
        pick = $urandom_range(99);
        // mostly absorb and squeeze, some loads and the odd no-op
        if (pick < 50) cmd = CMD_ABSORB;
        else if (pick < 78) cmd = CMD_SQUEEZE;
        else if (pick < 96) cmd = CMD_LOAD;
        else cmd = CMD_NOP;
        len = ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(16));
        send_item(cmd, 3'($urandom_range(7)), rand64(), rand64(), rand64(), len,
                  20'($urandom), 4'($urandom));
    endtask

    // ---------------- test tasks ----------------

    task automatic test_directed();
        logic [63:0] ones;
        ones = '1;
        // a load to every index, including the ignored ones above 4
        for (int k = 0; k < 8; k++)
            send_item(CMD_LOAD, k[2:0], (k % 2) ? ones : rand64(), '0, '0, '0, '0, '0);
        // squeeze with zero, one and the most rounds
        send_item(CMD_SQUEEZE, '0, '0, '0, '0, '0, '0, 4'd0);
        send_item(CMD_SQUEEZE, '0, '0, '0, '0, '0, '0, 4'd1);
        send_item(CMD_SQUEEZE, '0, '0, '0, '0, '0, '0, 4'd15);
        // empty, short, half, nearly full, full and oversized blocks
        send_item(CMD_ABSORB, '0, '0, ones, ones, 5'd0, '0, 4'd8);
        send_item(CMD_ABSORB, '0, '0, ones, ones, 5'd7, 20'hFFFFF, 4'd8);
        send_item(CMD_ABSORB, '0, '0, ones, ones, 5'd8, '0, 4'd8);
        send_item(CMD_ABSORB, '0, '0, ones, ones, 5'd15, 20'hFFFFF, 4'd15);
        send_item(CMD_ABSORB, '0, '0, ones, ones, 5'd16, 20'h003FF, 4'd0);
        send_item(CMD_ABSORB, '0, '0, rand64(), rand64(), 5'd17, 20'hFFC00, 4'd1);
        send_item(CMD_ABSORB, '0, '0, '0, '0, 5'd31, '0, 4'd15);
        // no-op command
        send_item(CMD_NOP, 3'd7, ones, ones, ones, 5'd31, 20'hFFFFF, 4'd15);
        send_item(CMD_SQUEEZE, '0, '0, '0, '0, '0, '0, 4'd5);
    endtask

    task automatic test_random(input int n, input int idle_pct, input int stall_pct);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (n) send_random_item();
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while the sender keeps pushing, then sender waits for a drain and sends more
    task automatic test_backpressure();
        recv_hold_cycles = 300;
        repeat (12) send_random_item();
        stop_sending();
        while (r_expect_q.size() != 0) @(negedge i_clk);
        repeat (20) send_random_item();
    endtask

    // ---------------- result checker ----------------

    always @(posedge i_clk) begin
        t_r_pair want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (r_expect_q.size() == 0) begin
                $display("%0t: unexpected result r_low=%h r_high=%h", $time, o_r_low, o_r_high);
                err_count++;
            end else begin
                want = r_expect_q.pop_front();
                if (o_r_low !== want.lo) begin
                    $display("%0t: r_low expected %h actual %h", $time, want.lo, o_r_low);
                    err_count++;
                end
                if (o_r_high !== want.hi) begin
                    $display("%0t: r_high expected %h actual %h", $time, want.hi, o_r_high);
                    err_count++;
                end
            end
        end
    end

    // receiver stall, with an optional long hold-off
    always @(negedge i_clk) begin
        if (recv_hold_cycles > 0) begin
            i_stall <= 1'b1;
            recv_hold_cycles <= recv_hold_cycles - 1;
        end else begin
            i_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        for (int k = 0; k < 5; k++) sp_c[k] = '0;
        sp_x_low = '0;
        sp_x_high = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        write_x(CFG_X_LOW, '1);
        write_x(CFG_X_HIGH, '1);
        test_directed();
        write_x(CFG_X_LOW, rand64());
        write_x(CFG_X_HIGH, rand64());
        write_x(3'd5, rand64());            // unused index, x must stay put
        test_random(400, 0, 0);
        write_x(CFG_X_LOW, 64'h0000_0000_FFFF_FFFF);
        write_x(CFG_X_HIGH, 64'hFFFF_FFFF_0000_0000);
        test_random(400, 55, 0);
        write_x(CFG_X_LOW, rand64());
        write_x(CFG_X_HIGH, rand64());
        test_random(400, 0, 55);
        test_backpressure();
        write_x(CFG_X_LOW, '0);
        write_x(CFG_X_HIGH, rand64());
        test_random(350, 6, 6);

        wait_drained();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule
